>>> src/fibonacci_mod_matrix_power_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Fibonacci matrix power core
// Implication checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FIBONACCI_MOD_MATRIX_POWER_CORE_ASSERT_SVH
`define FIBONACCI_MOD_MATRIX_POWER_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define FMP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define FMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fmp_pkg.sv
// ---------------------------------------------------------------------------
// fmp_pkg
// Shared widths, constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmp_pkg;

  localparam int MOD_W     = 16;          // modulus and matrix entry width
  localparam int PROD_W    = 2 * MOD_W;   // one product
  localparam int SUM_W     = PROD_W + 1;  // sum of two products
  localparam int CHUNK_W   = 8;           // dividend bits retired per cycle
  localparam int RED_STEPS = PROD_W / CHUNK_W;

  localparam logic [MOD_W-1:0] RESET_MODULUS = 16'd2021;
  localparam logic [1:0]       ENTRY_LAST    = 2'd3;
  localparam logic [1:0]       STEP_LAST     = 2'(RED_STEPS - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture index, modulus; set accumulator
    logic       mul1;       // first product of the current entry
    logic       mul2;       // second product of the current entry
    logic       red_load;   // add both products and seed the reducer
    logic       red_step;   // retire one chunk of the dividend
    logic       store;      // keep the reduced entry
    logic       qmul;       // multiply accumulator by the Q matrix
    logic       shift;      // move to the next exponent bit
    logic       emit;       // register the result
    logic [1:0] entry;      // matrix entry under work
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_zero;   // index on the input is zero
    logic exp_bit;    // current exponent bit
  } dp_sts_t;

endpackage

`default_nettype wire

>>> src/fmp_datapath.sv
// ---------------------------------------------------------------------------
// fmp_datapath
// Matrix accumulator, shared multiplier and chunked modular reducer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmp_datapath
  import fmp_pkg::*;
#(
  parameter int INDEX_BITS = 63
) (
  input  wire logic             clk,
  input  wire dp_cmd_t          cmd,
  input  wire logic [62:0]      in_index,
  input  wire logic [MOD_W-1:0] modulus,
  output dp_sts_t               sts,
  output logic      [MOD_W-1:0] fib_value
);

  logic [INDEX_BITS-1:0] exp_r;
  logic [MOD_W-1:0]      m_r;
  logic [MOD_W-1:0]      a_r, b_r, c_r, d_r;
  logic [MOD_W-1:0]      sq0_r, sq1_r, sq2_r;
  logic [PROD_W-1:0]     p1_r, p2_r;
  logic [PROD_W-1:0]     dvd_r;
  logic [MOD_W-1:0]      rem_r;
  logic [MOD_W-1:0]      out_r;

  logic [MOD_W-1:0]      m_eff;
  logic [MOD_W-1:0]      one_val;
  logic [MOD_W-1:0]      x1, y1, x2, y2, mul_x, mul_y;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      sum;
  logic [MOD_W-1:0]      rem_nxt;
  logic [MOD_W:0]        ab_sum, cd_sum;
  logic [MOD_W-1:0]      ab_mod, cd_mod;

  // Shift in eight dividend bits, keeping the partial remainder below m.
  function automatic logic [MOD_W-1:0] red_chunk(input logic [MOD_W-1:0] rem,
                                                 input logic [CHUNK_W-1:0] bits,
                                                 input logic [MOD_W-1:0] m);
    logic [MOD_W:0] r;
    r = {1'b0, rem};
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      r = {r[MOD_W-1:0], bits[i]};
      if (r >= {1'b0, m}) begin
        r = r - {1'b0, m};
      end
    end
    return r[MOD_W-1:0];
  endfunction

  // A zero modulus acts as one, which sends every entry to zero.
  assign m_eff   = (modulus == '0) ? MOD_W'(1) : modulus;
  assign one_val = (m_eff == MOD_W'(1)) ? '0 : MOD_W'(1);

  assign sts.idx_zero = (in_index[INDEX_BITS-1:0] == '0);
  assign sts.exp_bit  = exp_r[INDEX_BITS-1];

  // Squaring: each entry is the sum of two products of old entries.
  always_comb begin
    unique case (cmd.entry)
      2'd0: begin x1 = a_r; y1 = a_r; x2 = b_r; y2 = c_r; end
      2'd1: begin x1 = a_r; y1 = b_r; x2 = b_r; y2 = d_r; end
      2'd2: begin x1 = c_r; y1 = a_r; x2 = d_r; y2 = c_r; end
      default: begin x1 = c_r; y1 = b_r; x2 = d_r; y2 = d_r; end
    endcase
    mul_x = cmd.mul2 ? x2 : x1;
    mul_y = cmd.mul2 ? y2 : y1;
  end

  assign prod    = mul_x * mul_y;
  assign sum     = {1'b0, p1_r} + {1'b0, p2_r};
  assign rem_nxt = red_chunk(rem_r, dvd_r[PROD_W-1 -: CHUNK_W], m_r);

  // Multiplying by Q only needs additions: [[a+b, a], [c+d, c]].
  assign ab_sum = {1'b0, a_r} + {1'b0, b_r};
  assign cd_sum = {1'b0, c_r} + {1'b0, d_r};
  assign ab_mod = (ab_sum >= {1'b0, m_r}) ? MOD_W'(ab_sum - {1'b0, m_r}) : ab_sum[MOD_W-1:0];
  assign cd_mod = (cd_sum >= {1'b0, m_r}) ? MOD_W'(cd_sum - {1'b0, m_r}) : cd_sum[MOD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r   <= m_eff;
      exp_r <= in_index[INDEX_BITS-1:0] - INDEX_BITS'(1);
      a_r   <= sts.idx_zero ? '0 : one_val;
      b_r   <= '0;
      c_r   <= '0;
      d_r   <= one_val;
    end
    if (cmd.mul1) begin
      p1_r <= prod;
    end
    if (cmd.mul2) begin
      p2_r <= prod;
    end
    if (cmd.red_load) begin
      dvd_r <= sum[PROD_W-1:0];
      // The top sum bit seeds the remainder; with m of one it must be zero.
      rem_r <= {{(MOD_W-1){1'b0}}, sum[PROD_W] & (m_r != MOD_W'(1))};
    end
    if (cmd.red_step) begin
      dvd_r <= dvd_r << CHUNK_W;
      rem_r <= rem_nxt;
    end
    if (cmd.store) begin
      unique case (cmd.entry)
        2'd0: sq0_r <= rem_nxt;
        2'd1: sq1_r <= rem_nxt;
        2'd2: sq2_r <= rem_nxt;
        default: begin
          a_r <= sq0_r;
          b_r <= sq1_r;
          c_r <= sq2_r;
          d_r <= rem_nxt;
        end
      endcase
    end
    if (cmd.qmul) begin
      a_r <= ab_mod;
      b_r <= a_r;
      c_r <= cd_mod;
      d_r <= c_r;
    end
    if (cmd.shift) begin
      exp_r <= exp_r << 1;
    end
    if (cmd.emit) begin
      out_r <= a_r;
    end
  end

  assign fib_value = out_r;

endmodule

`default_nettype wire

>>> src/fmp_controller.sv
// ---------------------------------------------------------------------------
// fmp_controller
// Sequences square-and-multiply over the exponent bits, entry by entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fibonacci_mod_matrix_power_core_assert.svh"

module fmp_controller
  import fmp_pkg::*;
#(
  parameter int INDEX_BITS = 63
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output logic      out_valid,
  output dp_cmd_t   cmd,
  input  wire dp_sts_t sts
);

  localparam int BIT_W = $clog2(INDEX_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_MUL2  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_RED   = 3'd4;
  localparam logic [2:0] S_QSTEP = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic [1:0]       entry_r, entry_nxt;
  logic [1:0]       step_r, step_nxt;
  logic             out_valid_r;

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    entry_nxt = entry_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.entry = entry_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          bit_nxt   = BIT_W'(INDEX_BITS - 1);
          entry_nxt = '0;
          state_nxt = sts.idx_zero ? S_DONE : S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.red_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_RED;
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        step_nxt     = step_r + 2'd1;
        if (step_r == STEP_LAST) begin
          cmd.store = 1'b1;
          if (entry_r != ENTRY_LAST) begin
            entry_nxt = entry_r + 2'd1;
            state_nxt = S_MUL1;
          end else if (sts.exp_bit) begin
            state_nxt = S_QSTEP;
          end else begin
            cmd.shift = 1'b1;
            entry_nxt = '0;
            if (bit_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              bit_nxt   = bit_r - BIT_W'(1);
              state_nxt = S_MUL1;
            end
          end
        end
      end
      S_QSTEP: begin
        cmd.qmul  = 1'b1;
        cmd.shift = 1'b1;
        entry_nxt = '0;
        if (bit_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          bit_nxt   = bit_r - BIT_W'(1);
          state_nxt = S_MUL1;
        end
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_r       <= '0;
      entry_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_r       <= bit_nxt;
      entry_r     <= entry_nxt;
      step_r      <= step_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `FMP_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held two cycles")
  `FMP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `FMP_ASSERT_SAME(a_qstep_order, state_r == S_QSTEP, $past(state_r == S_RED && entry_r == ENTRY_LAST), "Q step not after last squared entry")

endmodule

`default_nettype wire

>>> src/fibonacci_mod_matrix_power_core.sv
// ---------------------------------------------------------------------------
// fibonacci_mod_matrix_power_core
// F(n) mod a programmable modulus by 2x2 matrix square-and-multiply.
// ---------------------------------------------------------------------------
// Index zero goes straight to the result; any other index squares the four
//   accumulator entries in turn for every exponent bit, from the top down.
// Each squared entry uses the one shared 16x16 multiplier and then the
//   8-bit-per-cycle remainder unit; a set exponent bit adds a Q step.
// A new word is taken only while idle, at the earliest in the strobe cycle.
// Reset: rst_n low clears the sequencer and loads the modulus with 2021.
`timescale 1ns / 1ps
`default_nettype none

module fibonacci_mod_matrix_power_core
  import fmp_pkg::*;
#(
  parameter int INDEX_BITS = 63
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel: a word is taken when start is high and busy is low.
  input  wire logic        start,
  output logic             busy,
  input  wire logic [62:0] in_index,
  // Result channel: one-cycle strobe, the receiver cannot stall it.
  output logic             out_valid,
  output logic [15:0]      out_fib_value,
  // Configuration port. The modulus sits at byte address 0.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [MOD_W-1:0] modulus_r;
  logic             cfg_wr;
  logic             cfg_hit;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  // The register is decoded on the word address; byte offset bits are ignored,
  // and any address beyond the single register reads as zero and drops writes.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= RESET_MODULUS;
    end else if (cfg_wr && cfg_hit) begin
      modulus_r <= pwdata[MOD_W-1:0];
    end
  end

  assign prdata = cfg_hit ? {{(32-MOD_W){1'b0}}, modulus_r} : '0;

  // The controller walks exponent bits from the top down. Every bit squares
  // the accumulator one entry at a time; a set bit then multiplies by Q.
  fmp_controller #(
    .INDEX_BITS(INDEX_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath snapshots the modulus when a word is taken, so the result
  // always reflects the modulus in force at that moment.
  fmp_datapath #(
    .INDEX_BITS(INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_index  (in_index),
    .modulus   (modulus_r),
    .sts       (sts),
    .fib_value (out_fib_value)
  );

endmodule

`default_nettype wire

>>> tb/tb_fibonacci_mod_matrix_power_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the Fibonacci-mod matrix power core
// Sends indices through the start/busy command port. A local square-and-
// multiply predictor computes F(n) mod the programmed modulus for each index,
// and every strobed result is checked against the oldest outstanding word.
// The modulus register is reprogrammed over the APB port between phases.
// ---------------------------------------------------------------------------

module tb_fibonacci_mod_matrix_power_core
  import fmp_pkg::*;
();

  localparam int               IDX_W        = 63;
  localparam logic [2:0]       MODULUS_ADDR = 3'd0;
  localparam logic [IDX_W-1:0] IDX_MAX      = {IDX_W{1'b1}};
  // Alternating bit patterns, complements of each other over all 63 bits.
  localparam logic [IDX_W-1:0] IDX_ALT_A    = 63'h5555_5555_5555_5555;
  localparam logic [IDX_W-1:0] IDX_ALT_B    = 63'h2AAA_AAAA_AAAA_AAAA;
  localparam logic [IDX_W-1:0] IDX_TOP_BIT  = 63'h4000_0000_0000_0000;
  localparam int               PHASES       = 6;
  localparam int               PHASE_WORDS  = 50;

  // One outstanding word: the index, the modulus in force when it was
  // accepted, and the residue the core must return for it.
  typedef struct {
    logic [IDX_W-1:0] index;
    logic [MOD_W-1:0] modv;
    logic [MOD_W-1:0] fib;
  } fib_word_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [IDX_W-1:0]  in_index;
  logic              out_valid;
  logic [MOD_W-1:0]  out_fib_value;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  fib_word_t         pending_fib[$];
  logic [MOD_W-1:0]  cur_modulus;
  bit                idle_on;
  int                mismatch_count;
  int                words_sent;
  int                results_checked;
  int                moduli_used;

  fibonacci_mod_matrix_power_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_fib_value (out_fib_value),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // F(n) mod m by raising Q = [[1,1],[1,0]] to the power n-1, scanning the
  // exponent from its top bit down. A zero modulus behaves as modulus one.
  // Entries stay below 2^16, so every sum of two products fits in 64 bits.
  function automatic logic [MOD_W-1:0] fib_residue(input logic [IDX_W-1:0] n,
                                                   input logic [MOD_W-1:0] modv);
    longint unsigned  m;
    longint unsigned  a00, a01, a10, a11;
    longint unsigned  t00, t01, t10, t11;
    logic [IDX_W-1:0] e;
    m = (modv == '0) ? 64'd1 : 64'(modv);
    if (n == '0) return '0;
    e   = n - 1'b1;
    a00 = 1 % m;
    a01 = 0;
    a10 = 0;
    a11 = 1 % m;
    for (int b = IDX_W - 1; b >= 0; b--) begin
      t00 = (a00 * a00 + a01 * a10) % m;
      t01 = (a00 * a01 + a01 * a11) % m;
      t10 = (a10 * a00 + a11 * a10) % m;
      t11 = (a10 * a01 + a11 * a11) % m;
      if (e[b]) begin
        // Right-multiplying by Q adds the two columns into the left one
        // and moves the old left column to the right.
        a00 = (t00 + t01) % m;
        a01 = t00 % m;
        a10 = (t10 + t11) % m;
        a11 = t10 % m;
      end else begin
        a00 = t00;
        a01 = t01;
        a10 = t10;
        a11 = t11;
      end
    end
    return a00[MOD_W-1:0];
  endfunction

  // Random index: mostly full-width or random-width values, with small
  // indices and zero mixed in.
  function automatic logic [IDX_W-1:0] rand_index();
    logic [63:0] raw;
    int          w;
    raw = {$urandom, $urandom};
    w   = $urandom_range(1, IDX_W);
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return IDX_W'($urandom_range(1, 200));
      3, 4, 5: return raw[IDX_W-1:0];
      default: return raw[IDX_W-1:0] & (IDX_MAX >> (IDX_W - w));
    endcase
  endfunction

  // Result checker. Every strobe is matched with the oldest outstanding
  // word; the core cannot be stalled, so each strobe is taken as it comes.
  always @(posedge clk) begin
    fib_word_t w;
    if (rst_n && out_valid) begin
      if (pending_fib.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, expected none, actual fib_value %0d",
                 $time, out_fib_value);
      end else begin
        w = pending_fib.pop_front();
        results_checked++;
        if (out_fib_value !== w.fib) begin
          mismatch_count++;
          $display("%0t ns: index %0d modulus %0d: expected fib_value %0d, actual %0d",
                   $time, w.index, w.modv, w.fib, out_fib_value);
        end
      end
    end
  end

  // Sends one word. Called and left at a falling edge. start stays high on
  // return, so a following call with no gap keeps the port busy without
  // lowering start in between.
  task automatic send_index(input logic [IDX_W-1:0] n);
    int        gap;
    fib_word_t w;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_index <= n;
    // The word is taken at the first rising edge that sees busy low.
    do @(posedge clk); while (busy !== 1'b0);
    w.index = n;
    w.modv  = cur_modulus;
    w.fib   = fib_residue(n, cur_modulus);
    pending_fib.push_back(w);
    words_sent++;
    @(negedge clk);
  endtask

  // Lowers start and waits until every outstanding result has been seen.
  // Each word gives exactly one result, so the core is idle afterward.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_fib.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the modulus register and reads it back in a second transfer
  // that follows directly, psel staying high across both.
  task automatic write_modulus(input logic [31:0] data);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODULUS_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    cur_modulus = data[MOD_W-1:0];
    moduli_used++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {{(32 - MOD_W){1'b0}}, cur_modulus}) begin
      mismatch_count++;
      $display("%0t ns: modulus readback: expected %0d, actual %0d",
               $time, cur_modulus, rd);
    end
  endtask

  // Indices at the reset modulus: zero, the first few, and the widest
  // exponents, including both alternating bit patterns.
  task automatic test_reset_modulus();
    idle_on = 1'b0;
    send_index('0);
    send_index(IDX_W'(1));
    send_index(IDX_W'(2));
    send_index(IDX_W'(3));
    send_index(IDX_W'(20));
    send_index(IDX_MAX);
    send_index(IDX_TOP_BIT);
    send_index(IDX_ALT_A);
    send_index(IDX_ALT_B);
    drain_results();
  endtask

  // Largest and smallest moduli, the degenerate moduli one and zero, and a
  // write whose upper data bits must be ignored.
  task automatic test_modulus_extremes();
    idle_on = 1'b1;
    write_modulus(32'h0000_FFFF);
    send_index(IDX_W'(1));
    send_index(IDX_W'(24));
    send_index(IDX_MAX);
    send_index(IDX_ALT_A);
    drain_results();
    write_modulus(32'h0000_0002);
    send_index(IDX_W'(1));
    send_index(IDX_W'(3));
    send_index(IDX_MAX);
    drain_results();
    write_modulus(32'h0000_0001);
    send_index(IDX_W'(1));
    send_index(IDX_MAX);
    drain_results();
    write_modulus(32'h0000_0000);
    send_index(IDX_W'(5));
    send_index(IDX_MAX);
    drain_results();
    write_modulus(32'hFFFF_0007);
    send_index(IDX_W'(8));
    send_index(IDX_ALT_B);
    drain_results();
  endtask

  // Random phases, each with its own modulus. Idling switches on and off
  // in runs so that some stretches are back to back.
  task automatic test_random_indices();
    logic [MOD_W-1:0] modv;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       modv = '1;
        1:       modv = MOD_W'($urandom_range(2, 64));
        default: modv = MOD_W'($urandom_range(2, 65535));
      endcase
      write_modulus({16'($urandom), modv});
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 9) == 0) idle_on = ~idle_on;
        send_index(rand_index());
      end
      drain_results();
    end
  endtask

  initial begin
    // All inputs known from time zero, with reset asserted from the start.
    rst_n           = 1'b0;
    start           = 1'b0;
    in_index        = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cur_modulus     = RESET_MODULUS;
    idle_on         = 1'b0;
    mismatch_count  = 0;
    words_sent      = 0;
    results_checked = 0;
    moduli_used     = 1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_modulus();
    test_modulus_extremes();
    test_random_indices();

    // Watch for stray strobes for about one full computation.
    repeat (2000) @(posedge clk);

    $display("Covered %0d words under %0d modulus settings, %0d results checked.",
             words_sent, moduli_used, results_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog. The slowest correct run is roughly 330 words, near 12 ms;
  // this allows about four times that.
  initial begin
    #50_000_000;
    $display("Watchdog expired with %0d words still outstanding.", pending_fib.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/fmp_pkg.sv
src/fmp_datapath.sv
src/fmp_controller.sv
src/fibonacci_mod_matrix_power_core.sv
tb/tb_fibonacci_mod_matrix_power_core.sv
